### hw/rtl/crdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crdm_pkg;

	// item field widths
	localparam int COUNT_W = 63;
	localparam int FREQ_W  = 32;
	localparam int KIND_W  = 2;
	localparam int MISS_W  = 8;

	// configuration
	localparam int BOUND_W = 7;
	localparam int THR_W   = 8;
	localparam int REF_W   = 32;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_LOW_BOUND  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_BOUND = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_REF_TICKS  = 2'd3;

	localparam logic [BOUND_W-1:0] RST_LOW_BOUND  = 7'd7;
	localparam logic [BOUND_W-1:0] RST_HIGH_BOUND = 7'd13;
	localparam logic [THR_W-1:0]   RST_THRESHOLD  = 8'd5;
	localparam logic [REF_W-1:0]   RST_REF_TICKS  = 32'd10000000;

	// sample kinds
	localparam logic [KIND_W-1:0] KIND_PRIMED  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SKIPPED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EVAL    = 2'd2;

	// shared multiplier: 64x64 built from 32x32 partial products
	localparam int MUL_W     = 64;
	localparam int HALF_W    = MUL_W / 2;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int NUM_PAIRS = 4;
	localparam int STEP_W    = 3;

	// parameter defaults
	localparam int DEF_COUNT_WIDTH = 63;
	localparam int DEF_FREQ_WIDTH  = 32;

	typedef struct packed {
		logic [BOUND_W-1:0] low_bound;
		logic [BOUND_W-1:0] high_bound;
		logic [THR_W-1:0]   threshold;
		logic [REF_W-1:0]   ref_ticks;
	} cfg_t;

endpackage

`default_nettype wire

### hw/rtl/crdm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface crdm_tick_if;
	logic                        valid;
	logic                        ready;
	logic [crdm_pkg::COUNT_W-1:0] perf_count;
	logic [crdm_pkg::FREQ_W-1:0]  perf_freq;
	logic [crdm_pkg::COUNT_W-1:0] sys_time;

	modport source (output valid, output perf_count, output perf_freq, output sys_time,
		input ready);
	modport sink (input valid, input perf_count, input perf_freq, input sys_time,
		output ready);
endinterface

interface crdm_verdict_if;
	logic                        valid;
	logic                        ready;
	logic [crdm_pkg::KIND_W-1:0] sample_kind;
	logic                        out_of_band;
	logic                        alarm;
	logic [crdm_pkg::MISS_W-1:0] miss_count;

	modport source (output valid, output sample_kind, output out_of_band, output alarm,
		output miss_count, input ready);
	modport sink (input valid, input sample_kind, input out_of_band, input alarm,
		input miss_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/crdm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module crdm_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crdm_pkg::ADDR_W-1:0]   paddr,
	input  logic [crdm_pkg::DATA_W-1:0]   pwdata,
	output logic [crdm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output crdm_pkg::cfg_t                cfg
);

	logic                              wr_en;
	logic [crdm_pkg::REG_IDX_W-1:0]    reg_idx;
	crdm_pkg::cfg_t                    cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[crdm_pkg::ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_bound  <= crdm_pkg::RST_LOW_BOUND;
			cfg_q.high_bound <= crdm_pkg::RST_HIGH_BOUND;
			cfg_q.threshold  <= crdm_pkg::RST_THRESHOLD;
			cfg_q.ref_ticks  <= crdm_pkg::RST_REF_TICKS;
		end else if (wr_en) begin
			unique case (reg_idx)
				crdm_pkg::REG_LOW_BOUND:  cfg_q.low_bound  <= pwdata[crdm_pkg::BOUND_W-1:0];
				crdm_pkg::REG_HIGH_BOUND: cfg_q.high_bound <= pwdata[crdm_pkg::BOUND_W-1:0];
				crdm_pkg::REG_THRESHOLD:  cfg_q.threshold  <= pwdata[crdm_pkg::THR_W-1:0];
				crdm_pkg::REG_REF_TICKS:  cfg_q.ref_ticks  <= pwdata[crdm_pkg::REF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			crdm_pkg::REG_LOW_BOUND:
				prdata = {{(crdm_pkg::DATA_W-crdm_pkg::BOUND_W){1'b0}}, cfg_q.low_bound};
			crdm_pkg::REG_HIGH_BOUND:
				prdata = {{(crdm_pkg::DATA_W-crdm_pkg::BOUND_W){1'b0}}, cfg_q.high_bound};
			crdm_pkg::REG_THRESHOLD:
				prdata = {{(crdm_pkg::DATA_W-crdm_pkg::THR_W){1'b0}}, cfg_q.threshold};
			crdm_pkg::REG_REF_TICKS:
				prdata = cfg_q.ref_ticks;
			default:
				prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/crdm_mul_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module crdm_mul_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [crdm_pkg::MUL_W-1:0]    a,
	input  logic [crdm_pkg::MUL_W-1:0]    b,
	output logic                          done,
	output logic [crdm_pkg::PROD_W-1:0]   prod
);

	localparam int MUL_W  = crdm_pkg::MUL_W;
	localparam int HALF_W = crdm_pkg::HALF_W;
	localparam int PROD_W = crdm_pkg::PROD_W;
	localparam int STEP_W = crdm_pkg::STEP_W;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(crdm_pkg::NUM_PAIRS);

	logic [MUL_W-1:0]  a_q, b_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [MUL_W-1:0]  pp_q;
	logic [1:0]        pp_sh_q;
	logic              pp_vld_q;
	logic [PROD_W-1:0] acc_q;
	logic              done_q;

	logic [1:0]        pair;
	logic [HALF_W-1:0] a_half, b_half;
	logic [PROD_W-1:0] pp_base, pp_ext;

	// pair bit 1 picks the upper half of a, bit 0 the upper half of b
	assign pair   = step_q[1:0];
	assign a_half = pair[1] ? a_q[MUL_W-1:HALF_W] : a_q[HALF_W-1:0];
	assign b_half = pair[0] ? b_q[MUL_W-1:HALF_W] : b_q[HALF_W-1:0];

	assign pp_base = {{(PROD_W-MUL_W){1'b0}}, pp_q};

	always_comb begin
		case (pp_sh_q)
			2'd0:    pp_ext = pp_base;
			2'd1:    pp_ext = pp_base << HALF_W;
			default: pp_ext = pp_base << MUL_W;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q      <= '0;
			b_q      <= '0;
			step_q   <= '0;
			busy_q   <= 1'b0;
			pp_q     <= '0;
			pp_sh_q  <= '0;
			pp_vld_q <= 1'b0;
			acc_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (pp_vld_q) begin
				acc_q <= acc_q + pp_ext;
			end
			if (start) begin
				a_q      <= a;
				b_q      <= b;
				acc_q    <= '0;
				step_q   <= '0;
				busy_q   <= 1'b1;
				pp_vld_q <= 1'b0;
			end else if (busy_q) begin
				if (step_q != LAST_STEP) begin
					pp_q     <= a_half * b_half;
					pp_sh_q  <= {1'b0, pair[1]} + {1'b0, pair[0]};
					pp_vld_q <= 1'b1;
					step_q   <= step_q + 1'b1;
				end else begin
					// last partial product is added on this edge
					pp_vld_q <= 1'b0;
					busy_q   <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q && !pp_vld_q)
		else $error("multiply started while busy");

endmodule

`default_nettype wire

### hw/rtl/clock_ratio_drift_monitor.sv
// a primed or skipped sample goes from ST_CLASS straight to ST_FINISH; an evaluated sample
// passes through ST_LAUNCH, ST_WAIT and ST_JUDGE before ST_FINISH
// throughput: one sample at a time; the next is accepted once the result is registered at the
// output, which waits while a held verdict is not taken; an evaluated sample needs five 64x64
// products, each four 32x32 passes through the one shared multiplier; reset: arst_n clears the
// stored count, time, frequency and miss counter and loads the register defaults; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module clock_ratio_drift_monitor #(
	parameter int COUNT_WIDTH = crdm_pkg::DEF_COUNT_WIDTH,
	parameter int FREQ_WIDTH  = crdm_pkg::DEF_FREQ_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	crdm_tick_if.sink                     tick,
	crdm_verdict_if.source                verdict,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crdm_pkg::ADDR_W-1:0]   paddr,
	input  logic [crdm_pkg::DATA_W-1:0]   pwdata,
	output logic [crdm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int MUL_W  = crdm_pkg::MUL_W;
	localparam int PROD_W = crdm_pkg::PROD_W;
	localparam int MISS_W = crdm_pkg::MISS_W;
	localparam int REF_W  = crdm_pkg::REF_W;
	localparam int R10_W  = REF_W + 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASS,
		ST_LAUNCH,
		ST_WAIT,
		ST_JUDGE,
		ST_FINISH
	} state_t;

	// products in the order they are formed
	typedef enum logic [2:0] {
		JOB_FLO,
		JOB_FHI,
		JOB_LHS,
		JOB_LOS,
		JOB_HIS
	} job_t;

	crdm_pkg::cfg_t cfg;

	state_t                   state_q;
	job_t                     job_q;
	logic [COUNT_WIDTH-1:0]   cur_count_q, cur_time_q, prev_count_q, prev_time_q;
	logic [FREQ_WIDTH-1:0]    cur_freq_q, prev_freq_q;
	logic [COUNT_WIDTH-1:0]   dc_q, dt_q;
	logic [MUL_W-1:0]         flo_q, fhi_q;
	logic [PROD_W-1:0]        lhs_q;
	logic                     below_q, above_q;
	logic [MISS_W-1:0]        misses_q;
	logic [crdm_pkg::KIND_W-1:0] res_kind_q, out_kind_q;
	logic                     res_oob_q, res_alarm_q, out_oob_q, out_alarm_q;
	logic [MISS_W-1:0]        res_miss_q, out_miss_q;
	logic                     out_valid_q;

	logic                     mul_start, mul_done;
	logic [MUL_W-1:0]         mul_a, mul_b;
	logic [PROD_W-1:0]        mul_prod;
	logic [R10_W-1:0]         r10;
	logic [MISS_W:0]          miss_inc;
	logic                     oob;

	crdm_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crdm_mul_unit u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// ten times the reference rate: 8r + 2r
	assign r10 = ({4'b0, cfg.ref_ticks} << 3) + ({4'b0, cfg.ref_ticks} << 1);

	always_comb begin
		unique case (job_q)
			JOB_FLO: begin
				mul_a = {{(MUL_W-FREQ_WIDTH){1'b0}}, prev_freq_q};
				mul_b = {{(MUL_W-crdm_pkg::BOUND_W){1'b0}}, cfg.low_bound};
			end
			JOB_FHI: begin
				mul_a = {{(MUL_W-FREQ_WIDTH){1'b0}}, prev_freq_q};
				mul_b = {{(MUL_W-crdm_pkg::BOUND_W){1'b0}}, cfg.high_bound};
			end
			JOB_LHS: begin
				mul_a = {{(MUL_W-COUNT_WIDTH){1'b0}}, dc_q};
				mul_b = {{(MUL_W-R10_W){1'b0}}, r10};
			end
			JOB_LOS: begin
				mul_a = flo_q;
				mul_b = {{(MUL_W-COUNT_WIDTH){1'b0}}, dt_q};
			end
			JOB_HIS: begin
				mul_a = fhi_q;
				mul_b = {{(MUL_W-COUNT_WIDTH){1'b0}}, dt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_start = (state_q == ST_LAUNCH);
	assign miss_inc  = {1'b0, misses_q} + 1'b1;
	assign oob       = below_q || above_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			job_q        <= JOB_FLO;
			cur_count_q  <= '0;
			cur_time_q   <= '0;
			cur_freq_q   <= '0;
			prev_count_q <= '0;
			prev_time_q  <= '0;
			prev_freq_q  <= '0;
			dc_q         <= '0;
			dt_q         <= '0;
			flo_q        <= '0;
			fhi_q        <= '0;
			lhs_q        <= '0;
			below_q      <= 1'b0;
			above_q      <= 1'b0;
			misses_q     <= '0;
			res_kind_q   <= crdm_pkg::KIND_PRIMED;
			res_oob_q    <= 1'b0;
			res_alarm_q  <= 1'b0;
			res_miss_q   <= '0;
			out_kind_q   <= crdm_pkg::KIND_PRIMED;
			out_oob_q    <= 1'b0;
			out_alarm_q  <= 1'b0;
			out_miss_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && verdict.ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (tick.valid) begin
						cur_count_q <= tick.perf_count[COUNT_WIDTH-1:0];
						cur_freq_q  <= FREQ_WIDTH'(tick.perf_freq);
						cur_time_q  <= tick.sys_time[COUNT_WIDTH-1:0];
						state_q     <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					res_oob_q   <= 1'b0;
					res_alarm_q <= 1'b0;
					res_miss_q  <= misses_q;
					if (prev_count_q == '0 || prev_freq_q == '0) begin
						prev_count_q <= cur_count_q;
						prev_time_q  <= cur_time_q;
						prev_freq_q  <= cur_freq_q;
						res_kind_q   <= crdm_pkg::KIND_PRIMED;
						state_q      <= ST_FINISH;
					end else if (cur_count_q <= prev_count_q || cur_time_q <= prev_time_q) begin
						prev_count_q <= cur_count_q;
						prev_time_q  <= cur_time_q;
						res_kind_q   <= crdm_pkg::KIND_SKIPPED;
						state_q      <= ST_FINISH;
					end else begin
						dc_q    <= cur_count_q - prev_count_q;
						dt_q    <= cur_time_q - prev_time_q;
						job_q   <= JOB_FLO;
						state_q <= ST_LAUNCH;
					end
				end
				ST_LAUNCH: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mul_done) begin
						state_q <= ST_LAUNCH;
						unique case (job_q)
							JOB_FLO: begin
								flo_q <= mul_prod[MUL_W-1:0];
								job_q <= JOB_FHI;
							end
							JOB_FHI: begin
								fhi_q <= mul_prod[MUL_W-1:0];
								job_q <= JOB_LHS;
							end
							JOB_LHS: begin
								lhs_q <= mul_prod;
								job_q <= JOB_LOS;
							end
							JOB_LOS: begin
								below_q <= lhs_q < mul_prod;
								job_q   <= JOB_HIS;
							end
							JOB_HIS: begin
								above_q <= lhs_q > mul_prod;
								state_q <= ST_JUDGE;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_JUDGE: begin
					res_kind_q   <= crdm_pkg::KIND_EVAL;
					res_oob_q    <= oob;
					res_alarm_q  <= 1'b0;
					prev_count_q <= cur_count_q;
					prev_time_q  <= cur_time_q;
					prev_freq_q  <= cur_freq_q;
					if (oob) begin
						// 9-bit compare so a lowered threshold still fires
						if (miss_inc >= {1'b0, cfg.threshold}) begin
							res_alarm_q <= 1'b1;
							misses_q    <= '0;
							res_miss_q  <= '0;
						end else begin
							misses_q   <= miss_inc[MISS_W-1:0];
							res_miss_q <= miss_inc[MISS_W-1:0];
						end
					end else if (misses_q != '0) begin
						misses_q   <= misses_q - 1'b1;
						res_miss_q <= misses_q - 1'b1;
					end else begin
						res_miss_q <= misses_q;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!out_valid_q || verdict.ready) begin
						out_kind_q  <= res_kind_q;
						out_oob_q   <= res_oob_q;
						out_alarm_q <= res_alarm_q;
						out_miss_q  <= res_miss_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign tick.ready          = (state_q == ST_IDLE);
	assign verdict.valid       = out_valid_q;
	assign verdict.sample_kind = out_kind_q;
	assign verdict.out_of_band = out_oob_q;
	assign verdict.alarm       = out_alarm_q;
	assign verdict.miss_count  = out_miss_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ST_WAIT)
		else $error("product finished outside the wait state");

	a_alarm_clears: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.alarm |-> verdict.out_of_band && verdict.miss_count == '0)
		else $error("alarm without a miss or with a nonzero count");

	a_oob_eval: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.out_of_band |-> verdict.sample_kind == crdm_pkg::KIND_EVAL)
		else $error("out of band flag on a sample that was not evaluated");

endmodule

`default_nettype wire

### bench/clock_ratio_drift_monitor_tb.sv
`timescale 1ns / 1ps

module clock_ratio_drift_monitor_tb;
	import crdm_pkg::*;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [FREQ_W-1:0]  freq;
		logic [COUNT_W-1:0] stamp;
	} tick_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              oob;
		logic              alarm;
		logic [MISS_W-1:0] miss;
	} verdict_t;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	crdm_tick_if    tick_ch();
	crdm_verdict_if verdict_ch();

	clock_ratio_drift_monitor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.verdict (verdict_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// drift predictor state and register copy
	logic [COUNT_W-1:0] last_count = '0;
	logic [COUNT_W-1:0] last_stamp = '0;
	logic [FREQ_W-1:0]  last_freq  = '0;
	logic [MISS_W-1:0]  miss_tally = '0;
	logic [BOUND_W-1:0] low_bound  = RST_LOW_BOUND;
	logic [BOUND_W-1:0] high_bound = RST_HIGH_BOUND;
	logic [THR_W-1:0]   threshold  = RST_THRESHOLD;
	logic [REF_W-1:0]   ref_ticks  = RST_REF_TICKS;

	tick_t       tick_backlog[$];
	verdict_t    verdict_due[$];
	int unsigned ticks_queued = 0;
	int unsigned err_count = 0;
	int unsigned tick_gap = 0;
	int unsigned stall_left = 0;
	logic        tick_fire = 1'b0;
	bit          idle_off = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (idle_off || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [COUNT_W-1:0] rand63();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[COUNT_W-1:0];
	endfunction

	function automatic logic [FREQ_W-1:0] pick_freq();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 8)
			return $urandom_range(1, 4000);
		if (r < 14)
			return $urandom;
		if (r < 19)
			return 32'd10_000_000;
		return '0;
	endfunction

	// exact cross-multiplied ratio check, updates the stored sample
	function automatic verdict_t judge_tick(input tick_t t);
		verdict_t v;
		logic [COUNT_W-1:0] dc;
		logic [COUNT_W-1:0] dt;
		logic [127:0] lhs;
		logic [127:0] lo_side;
		logic [127:0] hi_side;
		logic [MISS_W:0] bumped;
		v = '0;
		if (last_count == '0 || last_freq == '0) begin
			v.kind = KIND_PRIMED;
			last_count = t.count;
			last_stamp = t.stamp;
			last_freq = t.freq;
		end else if (t.count <= last_count || t.stamp <= last_stamp) begin
			v.kind = KIND_SKIPPED;
			last_count = t.count;
			last_stamp = t.stamp;
		end else begin
			dc = t.count - last_count;
			dt = t.stamp - last_stamp;
			lhs = 128'(dc) * 128'(ref_ticks) * 128'd10;
			lo_side = 128'(last_freq) * 128'(low_bound) * 128'(dt);
			hi_side = 128'(last_freq) * 128'(high_bound) * 128'(dt);
			v.kind = KIND_EVAL;
			if (lhs < lo_side || lhs > hi_side) begin
				v.oob = 1'b1;
				// compared one bit wider so a full counter never wraps
				bumped = {1'b0, miss_tally} + 1'b1;
				if (bumped >= {1'b0, threshold}) begin
					v.alarm = 1'b1;
					miss_tally = '0;
				end else begin
					miss_tally = bumped[MISS_W-1:0];
				end
			end else if (miss_tally != '0) begin
				miss_tally = miss_tally - 1'b1;
			end
			last_count = t.count;
			last_stamp = t.stamp;
			last_freq = t.freq;
		end
		v.miss = miss_tally;
		return v;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endfunction

	// tick requests: predict on acceptance, drive at the falling edge
	always @(posedge clk) begin
		tick_fire <= arst_n && tick_ch.valid && tick_ch.ready;
		if (arst_n && tick_ch.valid && tick_ch.ready)
			verdict_due.push_back(judge_tick(tick_t'{tick_ch.perf_count, tick_ch.perf_freq,
				tick_ch.sys_time}));
	end

	always @(negedge clk) begin : tick_drv
		tick_t nxt;
		if (arst_n && (!tick_ch.valid || tick_fire)) begin
			if (tick_gap != 0) begin
				tick_ch.valid <= 1'b0;
				tick_gap--;
			end else if (tick_backlog.size() != 0) begin
				nxt = tick_backlog.pop_front();
				tick_ch.perf_count <= nxt.count;
				tick_ch.perf_freq <= nxt.freq;
				tick_ch.sys_time <= nxt.stamp;
				tick_ch.valid <= 1'b1;
				tick_gap = pick_gap();
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			verdict_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			verdict_ch.ready <= 1'b1;
			if ($urandom_range(0, 99) < 25)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin : verdict_mon
		verdict_t want;
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin
			if (verdict_due.size() == 0) begin
				err_count++;
				$display("%0t: verdict with none pending, kind %0d oob %0d alarm %0d miss %0d",
					$time, verdict_ch.sample_kind, verdict_ch.out_of_band, verdict_ch.alarm,
					verdict_ch.miss_count);
			end else begin
				want = verdict_due.pop_front();
				check_field("sample_kind", want.kind, verdict_ch.sample_kind);
				check_field("out_of_band", want.oob, verdict_ch.out_of_band);
				check_field("alarm", want.alarm, verdict_ch.alarm);
				check_field("miss_count", want.miss, verdict_ch.miss_count);
			end
		end
	end

	task automatic apb_xfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
		input logic [DATA_W-1:0] wdata, input logic [DATA_W-1:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (!wr && prdata !== want) begin
			err_count++;
			$display("%0t: register %0d read expected %0h got %0h", $time, idx, want, prdata);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_set(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] shadow;
		shadow = '0;
		case (idx)
			REG_LOW_BOUND: begin
				low_bound = value[BOUND_W-1:0];
				shadow = DATA_W'(low_bound);
			end
			REG_HIGH_BOUND: begin
				high_bound = value[BOUND_W-1:0];
				shadow = DATA_W'(high_bound);
			end
			REG_THRESHOLD: begin
				threshold = value[THR_W-1:0];
				shadow = DATA_W'(threshold);
			end
			default: begin
				ref_ticks = value[REF_W-1:0];
				shadow = DATA_W'(ref_ticks);
			end
		endcase
		apb_xfer(1'b1, idx, value, shadow);
		apb_xfer(1'b0, idx, '0, shadow);
	endtask

	task automatic apply_cfg(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
		input logic [DATA_W-1:0] thr, input logic [DATA_W-1:0] rate);
		cfg_set(REG_LOW_BOUND, lo);
		cfg_set(REG_HIGH_BOUND, hi);
		cfg_set(REG_THRESHOLD, thr);
		cfg_set(REG_REF_TICKS, rate);
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (tick_backlog.size() != 0 || tick_ch.valid || verdict_due.size() != 0);
	endtask

	task automatic push_tick(input logic [COUNT_W-1:0] c, input logic [FREQ_W-1:0] f,
		input logic [COUNT_W-1:0] s);
		tick_backlog.push_back(tick_t'{c, f, s});
		ticks_queued++;
	endtask

	task automatic make_noise();
		logic [COUNT_W-1:0] c;
		logic [COUNT_W-1:0] s;
		c = rand63();
		s = rand63();
		if ($urandom_range(0, 1)) begin
			c = c >> $urandom_range(40, 62);
			s = s >> $urandom_range(40, 62);
		end
		push_tick(c, ($urandom_range(0, 5) == 0) ? FREQ_W'(0) : FREQ_W'($urandom), s);
	endtask

	// a fresh starting sample followed by samples aimed around the ratio bounds
	task automatic make_run();
		logic [COUNT_W-1:0] c;
		logic [COUNT_W-1:0] s;
		logic [COUNT_W-1:0] dc;
		logic [COUNT_W-1:0] dt;
		logic [FREQ_W-1:0]  f;
		logic [127:0]       span;
		int unsigned steps;
		int unsigned lo_m;
		int unsigned hi_m;
		int unsigned r_milli;
		lo_m = (low_bound < high_bound ? low_bound : high_bound) * 100;
		hi_m = (low_bound < high_bound ? high_bound : low_bound) * 100;
		f = pick_freq();
		c = ($urandom_range(0, 3) == 0) ? rand63() >> 2 : COUNT_W'($urandom_range(1, 100000));
		s = ($urandom_range(0, 3) == 0) ? rand63() >> 2 : COUNT_W'($urandom_range(0, 100000));
		if (c == '0)
			c = 1;
		push_tick(c, f, s);
		steps = $urandom_range(3, 20);
		repeat (steps) begin
			if ($urandom_range(0, 9) == 0) begin
				// broken sample: stalled count, falling count or stalled time
				case ($urandom_range(0, 2))
					0: s = s + 1 + $urandom_range(0, 1000);
					1: begin
						c = c >> 1;
						s = s + 1;
					end
					default: c = c + 1 + $urandom_range(0, 1000);
				endcase
				push_tick(c, pick_freq(), s);
			end else begin
				if ($urandom_range(0, 1))
					dt = COUNT_W'($urandom_range(1, 2000));
				else
					dt = COUNT_W'(ref_ticks >> 1) + COUNT_W'($urandom_range(0, ref_ticks)) + 1;
				case ($urandom_range(0, 4))
					0: r_milli = (lo_m >= 2 ? lo_m - 2 : 0) + $urandom_range(0, 4);
					1: r_milli = (hi_m >= 2 ? hi_m - 2 : 0) + $urandom_range(0, 4);
					2, 3: r_milli = $urandom_range(lo_m, hi_m);
					default: r_milli = $urandom_range(0, 15000);
				endcase
				if (ref_ticks == '0) begin
					dc = COUNT_W'($urandom_range(1, 5000));
				end else begin
					span = 128'(r_milli) * 128'(f) * 128'(dt) / (128'd1000 * 128'(ref_ticks));
					if (span > 128'(COUNT_MAX >> 2))
						return;
					dc = span[COUNT_W-1:0];
				end
				if (dc == '0 || $urandom_range(0, 3) == 0)
					dc = dc + 1;
				if (c > COUNT_MAX - dc || s > COUNT_MAX - dt)
					return;
				c = c + dc;
				s = s + dt;
				if ($urandom_range(0, 4) == 0)
					f = pick_freq();
				push_tick(c, f, s);
			end
		end
	endtask

	task automatic fill_items(input int unsigned n);
		int unsigned goal;
		goal = ticks_queued + n;
		while (ticks_queued < goal) begin
			if ($urandom_range(0, 99) < 15)
				make_noise();
			else
				make_run();
		end
	endtask

	initial begin : main
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.perf_count = '0;
		tick_ch.perf_freq = '0;
		tick_ch.sys_time = '0;
		verdict_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// priming with zero count and zero frequency
		push_tick('0, '0, '0);
		push_tick(COUNT_MAX, '0, 63'd5);
		push_tick(63'd1000, 32'd1000, '0);
		// unity ratio, exact bounds and just past them
		push_tick(63'd2000, 32'd1000, 63'd10_000_000);
		push_tick(63'd2700, 32'd1000, 63'd20_000_000);
		push_tick(63'd3399, 32'd1000, 63'd30_000_000);
		push_tick(63'd4699, 32'd1000, 63'd40_000_000);
		push_tick(63'd6000, 32'd1000, 63'd50_000_000);
		// stalled count, stalled time, count back to zero
		push_tick(63'd6000, 32'd1000, 63'd60_000_000);
		push_tick(63'd7000, 32'd1000, 63'd60_000_000);
		push_tick('0, 32'd1000, 63'd70_000_000);
		push_tick(63'd100, 32'hFFFF_FFFF, 63'd90_000_000);
		push_tick(COUNT_MAX, 32'd1000, COUNT_MAX);
		push_tick('0, 32'd5, '0);
		push_tick(63'd10, 32'd1000, 63'd1);
		// far too slow until the alarm fires, then in band at zero
		push_tick(63'd11, 32'd1000, 63'd10_000_001);
		push_tick(63'd12, 32'd1000, 63'd20_000_001);
		push_tick(63'd13, 32'd1000, 63'd30_000_001);
		push_tick(63'd1013, 32'd1000, 63'd40_000_001);
		wait_drained();

		// crossed bounds, then the threshold drops under the miss count
		cfg_set(REG_LOW_BOUND, 127);
		cfg_set(REG_HIGH_BOUND, 0);
		cfg_set(REG_THRESHOLD, 255);
		push_tick('0, 32'd1, '0);
		for (int i = 1; i <= 6; i++)
			push_tick(COUNT_W'(i), 32'd1, COUNT_W'(i));
		wait_drained();
		cfg_set(REG_THRESHOLD, 2);
		push_tick(63'd7, 32'd1, 63'd7);
		wait_drained();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: apply_cfg(7, 13, 5, 10_000_000);
				1: apply_cfg(0, 127, 255, 1);
				2: apply_cfg(127, 0, 1, 32'hFFFF_FFFF);
				3: apply_cfg(9, 11, 3, 1000);
				4: apply_cfg(100, 100, 0, 0);
				5: apply_cfg($urandom_range(0, 100), $urandom_range(0, 100),
					$urandom_range(1, 255), $urandom);
				default: apply_cfg(5, 20, 2, $urandom_range(1, 100000));
			endcase
			idle_off = (ph == 3);
			fill_items(75);
			if (ph == 1)
				wait_drained();
			fill_items(75);
			wait_drained();
		end
		idle_off = 1'b0;

		repeat (64) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
